/* rtl/core/etk_pkg.sv */
`default_nettype none

package etk_pkg;

	// width of the internal position counter, wraps modulo 2**POS_WIDTH
	localparam int POS_WIDTH = 16;
	localparam int OUT_POS_WIDTH = 16;

	// entries in the token output queue
	localparam int TOK_QUEUE_DEPTH = 4;

	// token kinds as reported on the result word
	typedef enum logic [3:0] {
		KIND_IDENT  = 4'd0,
		KIND_NUMBER = 4'd1,
		KIND_LPAREN = 4'd2,
		KIND_RPAREN = 4'd3,
		KIND_COMMA  = 4'd4,
		KIND_PLUS   = 4'd5,
		KIND_MINUS  = 4'd6,
		KIND_MULT   = 4'd7,
		KIND_DIV    = 4'd8,
		KIND_ERROR  = 4'd9
	} kind_t;

	// characters with a meaning of their own
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_MULT       = 8'h2A;
	localparam logic [7:0] CH_DIV        = 8'h2F;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_char;
	} char_word_t;

	typedef struct packed {
		kind_t                     kind;
		logic [OUT_POS_WIDTH-1:0] tok_start;
		logic [OUT_POS_WIDTH-1:0] tok_end;
		logic                      run_last;
	} tok_word_t;

endpackage

`default_nettype wire

/* rtl/core/expression_tokenizer_unit.sv */
`default_nettype none

// Character-at-a-time lexer for arithmetic expressions. One character word is
// taken per cycle on the char channel, last_char marking the end of the
// expression; tokens come out on the tok channel as kind plus start/end
// positions (identifiers, numbers, parens, comma, + - * /, or one error
// word at the first bad character, after which input is swallowed until the
// last character). Each character is classified and the lexer state updated
// in the cycle it is accepted, and its zero, one or two token words go into a
// four-entry output queue. A character is accepted every cycle while the
// queue holds at most two words, so the sustained rate is one character per
// cycle, bounded by one token word per cycle on the output side; a character
// that closes a token and is itself a token makes two token words.
// The lexer state returns to its reset state after the last character.
module expression_tokenizer_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        char_valid,
	output logic                       char_stall,
	input  wire  etk_pkg::char_word_t  char_word,
	output logic                       tok_valid,
	input  wire                        tok_stall,
	output etk_pkg::tok_word_t         tok_word
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_IDENT = 2'd1,
		ST_INT   = 2'd2,
		ST_FRAC  = 2'd3
	} lex_state_t;

	// lexer state
	lex_state_t                       state_q;
	logic [etk_pkg::POS_WIDTH-1:0]    tstart_q;
	logic [etk_pkg::POS_WIDTH-1:0]    pos_q;
	logic                             err_q;

	// output queue, head at entry 0
	etk_pkg::tok_word_t               queue_q [etk_pkg::TOK_QUEUE_DEPTH];
	logic [2:0]                       count_q;

	logic char_acc;
	logic tok_acc;

	assign char_stall = (count_q > 3'd2);
	assign char_acc   = char_valid && !char_stall;
	assign tok_valid  = (count_q != 3'd0);
	assign tok_acc    = tok_valid && !tok_stall;
	assign tok_word   = queue_q[0];

	// character classes
	logic [7:0]     c;
	logic           is_letter;
	logic           is_digit;
	logic           is_sep;
	logic           is_space;
	etk_pkg::kind_t sep_kind;

	assign c = char_word.ch;
	assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
		|| (c == etk_pkg::CH_UNDERSCORE);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_space = (c == etk_pkg::CH_SPACE);

	always_comb begin
		is_sep   = 1'b1;
		sep_kind = etk_pkg::KIND_ERROR;
		case (c)
			etk_pkg::CH_SPACE:  sep_kind = etk_pkg::KIND_ERROR;
			etk_pkg::CH_LPAREN: sep_kind = etk_pkg::KIND_LPAREN;
			etk_pkg::CH_RPAREN: sep_kind = etk_pkg::KIND_RPAREN;
			etk_pkg::CH_COMMA:  sep_kind = etk_pkg::KIND_COMMA;
			etk_pkg::CH_PLUS:   sep_kind = etk_pkg::KIND_PLUS;
			etk_pkg::CH_MINUS:  sep_kind = etk_pkg::KIND_MINUS;
			etk_pkg::CH_MULT:   sep_kind = etk_pkg::KIND_MULT;
			etk_pkg::CH_DIV:    sep_kind = etk_pkg::KIND_DIV;
			default:            is_sep = 1'b0;
		endcase
	end

	// next lexer state and the token words this character makes
	lex_state_t                    state_d;
	logic [etk_pkg::POS_WIDTH-1:0] tstart_d;
	logic [etk_pkg::POS_WIDTH-1:0] pos_inc;
	logic                          bad;
	logic                          emit_open;
	logic                          emit_sep;
	logic                          emit_flush;
	etk_pkg::kind_t                open_kind;
	etk_pkg::kind_t                flush_kind;
	etk_pkg::tok_word_t            r0;
	etk_pkg::tok_word_t            r1;
	logic [1:0]                    nres;

	assign pos_inc = pos_q + 1'b1;

	always_comb begin
		state_d   = state_q;
		tstart_d  = tstart_q;
		bad       = 1'b0;
		emit_open = 1'b0;
		emit_sep  = 1'b0;
		if (!err_q) begin
			if (is_sep) begin
				// separator closes any open token
				emit_open = (state_q != ST_IDLE);
				emit_sep  = !is_space;
				state_d   = ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: begin
						tstart_d = pos_q;
						if (is_letter)
							state_d = ST_IDENT;
						else if (is_digit)
							state_d = ST_INT;
						else if (c == etk_pkg::CH_DOT)
							state_d = ST_FRAC;
						else
							bad = 1'b1;
					end
					ST_IDENT: bad = !(is_letter || is_digit);
					ST_INT: begin
						if (c == etk_pkg::CH_DOT)
							state_d = ST_FRAC;
						else
							bad = !is_digit;
					end
					default: bad = !is_digit;
				endcase
			end
		end
		// token still open at the end of the expression gets flushed
		emit_flush = !err_q && !bad && char_word.last_char && (state_d != ST_IDLE);
	end

	assign open_kind  = (state_q == ST_IDENT) ? etk_pkg::KIND_IDENT : etk_pkg::KIND_NUMBER;
	assign flush_kind = (state_d == ST_IDENT) ? etk_pkg::KIND_IDENT : etk_pkg::KIND_NUMBER;

	always_comb begin
		r0 = '{kind: sep_kind, tok_start: etk_pkg::OUT_POS_WIDTH'(pos_q),
			tok_end: etk_pkg::OUT_POS_WIDTH'(pos_q), run_last: 1'b1};
		r1 = r0;
		nres = 2'd0;
		if (emit_open) begin
			r0.kind      = open_kind;
			r0.tok_start = etk_pkg::OUT_POS_WIDTH'(tstart_q);
			r0.run_last  = !emit_sep;
			nres         = emit_sep ? 2'd2 : 2'd1;
		end else if (emit_sep) begin
			nres = 2'd1;
		end else if (bad) begin
			r0.kind = etk_pkg::KIND_ERROR;
			nres    = 2'd1;
		end else if (emit_flush) begin
			r0.kind      = flush_kind;
			r0.tok_start = etk_pkg::OUT_POS_WIDTH'(tstart_d);
			r0.tok_end   = etk_pkg::OUT_POS_WIDTH'(pos_inc);
			nres         = 2'd1;
		end
	end

	// queue update: pop the head, then append this character's words
	logic [2:0] base;
	logic [2:0] count_d;

	assign base    = count_q - {2'd0, tok_acc};
	assign count_d = base + (char_acc ? {1'b0, nres} : 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tstart_q <= '0;
			pos_q    <= '0;
			err_q    <= 1'b0;
			count_q  <= 3'd0;
		end else begin
			count_q <= count_d;
			if (char_acc) begin
				if (char_word.last_char) begin
					state_q  <= ST_IDLE;
					tstart_q <= '0;
					pos_q    <= '0;
					err_q    <= 1'b0;
				end else begin
					state_q  <= state_d;
					tstart_q <= tstart_d;
					pos_q    <= pos_inc;
					err_q    <= err_q || bad;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < etk_pkg::TOK_QUEUE_DEPTH; k++) begin
			if (char_acc && (nres != 2'd0) && (3'(k) == base))
				queue_q[k] <= r0;
			else if (char_acc && (nres == 2'd2) && (3'(k) == base + 3'd1))
				queue_q[k] <= r1;
			else if (tok_acc && (k < etk_pkg::TOK_QUEUE_DEPTH - 1))
				queue_q[k] <= queue_q[2'(k + 1)];
		end
	end

endmodule

`default_nettype wire

/* tb/expression_tokenizer_unit_test.sv */
module expression_tokenizer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// lexer states of the predictor, same meaning as inside the block
	typedef enum logic [1:0] {
		LX_IDLE,
		LX_IDENT,
		LX_INT,
		LX_FRAC
	} lex_state_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	etk_pkg::char_word_t char_word  = '0;
	logic                tok_valid;
	logic                tok_stall  = 1'b0;
	etk_pkg::tok_word_t  tok_word;

	// predictor state
	lex_state_t                    lex       = LX_IDLE;
	logic [etk_pkg::POS_WIDTH-1:0] tok_begin = '0;
	logic [etk_pkg::POS_WIDTH-1:0] cur_pos   = '0;
	logic                          in_error  = 1'b0;

	// token words still owed by the block, oldest first
	etk_pkg::tok_word_t tokens_due[$];

	int fail_count    = 0;
	int tok_count     = 0;
	int live_chars    = 0;	// characters seen while not swallowing after an error
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;	// forced stall stretch on the token side, in cycles

	expression_tokenizer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_word   (tok_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic char_is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == etk_pkg::CH_UNDERSCORE;
	endfunction

	function automatic logic char_is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// kind of the identifier or number that is currently open
	function automatic etk_pkg::kind_t open_kind();
		return (lex == LX_IDENT) ? etk_pkg::KIND_IDENT : etk_pkg::KIND_NUMBER;
	endfunction

	function automatic etk_pkg::tok_word_t make_token(input etk_pkg::kind_t k,
		input logic [etk_pkg::POS_WIDTH-1:0] s, input logic [etk_pkg::POS_WIDTH-1:0] e);
		etk_pkg::tok_word_t t;
		t.kind      = k;
		t.tok_start = s;
		t.tok_end   = e;
		t.run_last  = 1'b0;
		return t;
	endfunction

	// advance the lexer by one accepted character, queue the token words it causes
	function automatic void lex_char(input logic [7:0] c, input logic fin);
		etk_pkg::tok_word_t            fresh [2];
		int                            n;
		etk_pkg::kind_t                sk;
		logic                          is_sep;
		logic                          bad;
		logic [etk_pkg::POS_WIDTH-1:0] here;
		here = cur_pos;
		n    = 0;
		sk   = etk_pkg::KIND_ERROR;
		if (!in_error) begin
			is_sep = 1'b1;
			case (c)
				etk_pkg::CH_LPAREN: sk = etk_pkg::KIND_LPAREN;
				etk_pkg::CH_RPAREN: sk = etk_pkg::KIND_RPAREN;
				etk_pkg::CH_COMMA:  sk = etk_pkg::KIND_COMMA;
				etk_pkg::CH_PLUS:   sk = etk_pkg::KIND_PLUS;
				etk_pkg::CH_MINUS:  sk = etk_pkg::KIND_MINUS;
				etk_pkg::CH_MULT:   sk = etk_pkg::KIND_MULT;
				etk_pkg::CH_DIV:    sk = etk_pkg::KIND_DIV;
				default:            is_sep = 1'b0;
			endcase
			if (is_sep || c == etk_pkg::CH_SPACE) begin
				// separator closes the open token first, ending at the separator
				if (lex != LX_IDLE) begin
					fresh[n] = make_token(open_kind(), tok_begin, here);
					n++;
					lex = LX_IDLE;
				end
				if (is_sep) begin
					fresh[n] = make_token(sk, here, here);
					n++;
				end
			end else begin
				bad = 1'b0;
				case (lex)
					LX_IDLE: begin
						tok_begin = here;
						if (char_is_letter(c))
							lex = LX_IDENT;
						else if (char_is_digit(c))
							lex = LX_INT;
						else if (c == etk_pkg::CH_DOT)
							lex = LX_FRAC;
						else
							bad = 1'b1;
					end
					LX_IDENT: bad = !(char_is_letter(c) || char_is_digit(c));
					LX_INT: begin
						if (c == etk_pkg::CH_DOT)
							lex = LX_FRAC;
						else if (!char_is_digit(c))
							bad = 1'b1;
					end
					default: bad = !char_is_digit(c);
				endcase
				if (bad) begin
					fresh[n] = make_token(etk_pkg::KIND_ERROR, here, here);
					n++;
					in_error = 1'b1;
				end
			end
			// token still open at the end of the string ends at the string length
			if (fin && !in_error && lex != LX_IDLE) begin
				fresh[n] = make_token(open_kind(), tok_begin, here + 1'b1);
				n++;
			end
		end
		if (n > 0)
			fresh[n-1].run_last = 1'b1;
		for (int k = 0; k < n; k++)
			tokens_due = {tokens_due, fresh[k]};
		if (fin) begin
			lex       = LX_IDLE;
			tok_begin = '0;
			cur_pos   = '0;
			in_error  = 1'b0;
		end else begin
			cur_pos = here + 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch: %s", msg);
	endtask

	// compare every accepted token word against the oldest one owed
	always @(posedge clk) begin
		etk_pkg::tok_word_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tokens_due.size() == 0) begin
				report_mismatch($sformatf("token word %0d not owed: kind %0d start %0d end %0d",
					tok_count, tok_word.kind, tok_word.tok_start, tok_word.tok_end));
			end else begin
				want = tokens_due.pop_front();
				if (tok_word.kind !== want.kind || tok_word.tok_start !== want.tok_start ||
					tok_word.tok_end !== want.tok_end || tok_word.run_last !== want.run_last) begin
					report_mismatch($sformatf(
						"token word %0d: got %0d/%0d/%0d/%0b want %0d/%0d/%0d/%0b",
						tok_count, tok_word.kind, tok_word.tok_start, tok_word.tok_end,
						tok_word.run_last, want.kind, want.tok_start, want.tok_end,
						want.run_last));
				end
			end
			tok_count++;
		end
	end

	// token side stall: a forced hold-off stretch wins over the random stall
	always @(posedge clk) begin
		if (hold_left > 0) begin
			tok_stall <= 1'b1;
			hold_left--;
		end else begin
			tok_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------------------------------------------------------- driving

	// offer one character word, optionally after a gap, and wait until it is taken
	task automatic send_char(input logic [7:0] c, input logic fin);
		etk_pkg::char_word_t w;
		int                  gap;
		w.ch        = c;
		w.last_char = fin;
		gap         = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (!in_error)
			live_chars++;
		char_valid <= 1'b1;
		char_word  <= w;
		do @(posedge clk); while (char_stall);
		lex_char(c, fin);
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		for (int k = 0; k < text.size(); k++)
			send_char(text[k], k == text.size() - 1);
	endtask

	task automatic send_string(input string s);
		logic [7:0] text[$];
		for (int k = 0; k < s.len(); k++)
			text = {text, s[k]};
		send_text(text);
	endtask

	// stop offering and wait until every owed token word has come out
	task automatic drain();
		char_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- random text

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		return etk_pkg::CH_UNDERSCORE;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_separator();
		case ($urandom_range(6))
			0:       return etk_pkg::CH_LPAREN;
			1:       return etk_pkg::CH_RPAREN;
			2:       return etk_pkg::CH_COMMA;
			3:       return etk_pkg::CH_PLUS;
			4:       return etk_pkg::CH_MINUS;
			5:       return etk_pkg::CH_MULT;
			default: return etk_pkg::CH_DIV;
		endcase
	endfunction

	// mostly lexer-relevant characters, with any byte at all now and then
	function automatic logic [7:0] rand_noise_char();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return rand_letter();
		else if (r < 45)
			return rand_digit();
		else if (r < 52)
			return etk_pkg::CH_DOT;
		else if (r < 72)
			return rand_separator();
		else if (r < 80)
			return etk_pkg::CH_SPACE;
		return 8'($urandom_range(255));
	endfunction

	// identifiers, numbers, separators and spaces in legal order
	task automatic send_wellformed_expr();
		logic [7:0] text[$];
		int         toks;
		int         len;
		logic       prev_word;
		toks      = $urandom_range(1, 6);
		prev_word = 1'b0;
		for (int t = 0; t < toks; t++) begin
			case ($urandom_range(3))
				0, 1: begin
					// two words in a row need something between them
					if (prev_word)
						text = {text,
							($urandom_range(1) ? etk_pkg::CH_SPACE : rand_separator())};
					if ($urandom_range(1)) begin
						text = {text, rand_letter()};
						len = $urandom_range(0, 5);
						for (int k = 0; k < len; k++)
							text = {text,
								($urandom_range(2) == 0 ? rand_digit() : rand_letter())};
					end else begin
						case ($urandom_range(3))
							0: len = 0;		// digits only
							1: len = 1;		// digits . digits
							2: len = 2;		// . digits
							default: len = 3;	// digits .
						endcase
						if (len != 2)
							repeat ($urandom_range(1, 4)) text = {text, rand_digit()};
						if (len != 0)
							text = {text, etk_pkg::CH_DOT};
						if (len == 1 || len == 2)
							repeat ($urandom_range(1, 4)) text = {text, rand_digit()};
					end
					prev_word = 1'b1;
				end
				2: begin
					text = {text, rand_separator()};
					prev_word = 1'b0;
				end
				default: begin
					repeat ($urandom_range(1, 2)) text = {text, etk_pkg::CH_SPACE};
					prev_word = 1'b0;
				end
			endcase
		end
		send_text(text);
	endtask

	task automatic send_noise_expr();
		logic [7:0] text[$];
		repeat ($urandom_range(1, 10)) text = {text, rand_noise_char()};
		send_text(text);
	endtask

	// ---------------------------------------------------------------- tests

	// every token kind, open token flushed at the end, errors and swallowed input
	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_string("_a9+(1.5)");
		send_string(",x-.2/3*y");
		// error on the letter, the separators after it are swallowed
		send_string("4z+(");
		// top byte is bad from the idle state, the zero byte after it is ignored
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_random(input int items, input int sender_pct, input int receiver_pct);
		int target;
		send_idle_pct = sender_pct;
		stall_pct     = receiver_pct;
		target        = live_chars + items;
		while (live_chars < target) begin
			if ($urandom_range(3) == 0)
				send_noise_expr();
			else
				send_wellformed_expr();
		end
		drain();
	endtask

	// token side holds off long enough for the output queue to fill and stall input
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = 300;
		send_string("a+(b1,2.5)*c/d-(e,.7)+f9*(1,2)/_z");
		// sender pauses here until every token word is out
		drain();
		send_string("((x))");
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(125, 0, 0);
		test_random(125, 66, 0);
		test_random(125, 0, 66);
		test_random(125, 34, 34);
		test_backpressure();

		stall_pct = 0;
		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
